// ----- rtl/core/swdte_pkg.sv -----
// ----------------------------------------------------------------------------
// SWD transfer engine package
// Item types, register indexes, acknowledge and status codes shared by the
// transfer engine, its sequencer and its checker.
// ----------------------------------------------------------------------------
package swdte_pkg;

   localparam int unsigned DATA_WORD_BITS = 32;
   localparam logic [5:0]  DATA_BITS      = 6'd33;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] CSR_TURNAROUND = 2'd0;
   localparam logic [1:0] CSR_DATA_PHASE = 2'd1;
   localparam logic [1:0] CSR_IDLE_COUNT = 2'd2;

   localparam logic [2:0] ACK_OK    = 3'b001;
   localparam logic [2:0] ACK_WAIT  = 3'b010;
   localparam logic [2:0] ACK_FAULT = 3'b100;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_WAIT     = 3'd1;
   localparam logic [2:0] STATUS_FAULT    = 3'd2;
   localparam logic [2:0] STATUS_PARITY   = 3'd3;
   localparam logic [2:0] STATUS_PROTOCOL = 3'd4;

   typedef struct packed {
      logic                      op;
      logic                      req_ap_not_dp;
      logic                      req_read;
      logic [1:0]                req_addr;
      logic [DATA_WORD_BITS-1:0] write_data;
      logic                      swdio_sample;
   } swdte_req_type;

   typedef struct packed {
      logic                      swdio_out;
      logic                      swdio_drive;
      logic                      clock_active;
      logic                      done_res;
      logic [2:0]                status;
      logic [2:0]                ack_bits;
      logic [DATA_WORD_BITS-1:0] read_data;
   } swdte_rsp_type;

   typedef struct packed {
      logic [1:0] addr;
      logic [7:0] wdata;
   } swdte_csr_type;

   typedef struct packed {
      logic [2:0] turnaround_cycles;
      logic       data_phase_on_wait;
      logic [7:0] idle_cycle_count;
   } swdte_cfg_type;

endpackage

// ----- rtl/core/swdte_chan_if.sv -----
// ----------------------------------------------------------------------------
// SWD transfer engine channel
// A valid/ready channel that carries one payload item per handshake.
// ----------------------------------------------------------------------------
interface swdte_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/core/swdte_seq.sv -----
// ----------------------------------------------------------------------------
// SWD transfer sequencer
// Holds the transfer state and works out, for each accepted item, the next
// state and the result of that SWCLK period.
// ----------------------------------------------------------------------------
module swdte_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  swdte_pkg::swdte_req_type item,
   input  swdte_pkg::swdte_cfg_type cfg,
   output swdte_pkg::swdte_rsp_type result
);
   import swdte_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_HDR, PH_TRN_ACK, PH_ACK, PH_RDATA, PH_TRN_R, PH_TRN_W,
      PH_WDATA, PH_IDLECYC, PH_WF_RDATA, PH_WF_TRN, PH_WF_WDATA, PH_ERR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [31:0] shift_ff, shift_in;
   logic        parity_ff, parity_in;
   logic [3:0]  request_ff, request_in;
   logic [2:0]  ack_ff, ack_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  idle_count_ff, idle_count_in;

   logic [2:0]  turn_len;
   logic [5:0]  err_len;
   logic [5:0]  count_inc;
   logic [7:0]  header;
   logic [2:0]  ack_next;
   logic        is_read;
   logic        level;
   logic        drive;
   logic        clock_on;
   logic        finish;
   logic        after_ok;

   assign turn_len  = (cfg.turnaround_cycles == 3'd0) ? 3'd1 : cfg.turnaround_cycles;
   assign err_len   = {3'b000, turn_len} + DATA_BITS;
   assign count_inc = bit_count_ff + 6'd1;
   assign is_read   = request_ff[1];
   // Park, stop, parity, A3, A2, RnW, APnDP, start from the top bit down.
   assign header    = {1'b1, 1'b0, ^request_ff, request_ff, 1'b1};
   assign ack_next  = ack_ff | 3'({2'b00, item.swdio_sample} << bit_count_ff[1:0]);

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      parity_in     = parity_ff;
      request_in    = request_ff;
      ack_in        = ack_ff;
      status_in     = status_ff;
      idle_count_in = idle_count_ff;
      level         = 1'b0;
      drive         = 1'b0;
      clock_on      = 1'b1;
      finish        = 1'b0;
      after_ok      = 1'b0;

      if (item.op == OP_START || phase_ff == PH_IDLE) begin
         level    = 1'b1;
         drive    = 1'b1;
         clock_on = 1'b0;
         if (item.op == OP_START && phase_ff == PH_IDLE) begin
            request_in    = {item.req_addr, item.req_read, item.req_ap_not_dp};
            shift_in      = item.write_data;
            parity_in     = ^item.write_data;
            ack_in        = 3'd0;
            status_in     = STATUS_OK;
            bit_count_in  = 6'd0;
            idle_count_in = 8'd0;
            phase_in      = PH_HDR;
         end
      end else begin
         case (phase_ff)
            PH_HDR: begin
               drive        = 1'b1;
               level        = header[bit_count_ff[2:0]];
               bit_count_in = count_inc;
               if (count_inc >= 6'd8) begin
                  bit_count_in = 6'd0;
                  phase_in     = PH_TRN_ACK;
               end
            end
            PH_TRN_ACK: begin
               bit_count_in = count_inc;
               if (count_inc >= {3'b000, turn_len}) begin
                  bit_count_in = 6'd0;
                  phase_in     = PH_ACK;
               end
            end
            PH_ACK: begin
               ack_in       = ack_next;
               bit_count_in = count_inc;
               if (count_inc >= 6'd3) begin
                  bit_count_in = 6'd0;
                  if (ack_next == ACK_OK) begin
                     status_in = STATUS_OK;
                     if (is_read) begin
                        shift_in  = 32'd0;
                        parity_in = 1'b0;
                        phase_in  = PH_RDATA;
                     end else begin
                        phase_in = PH_TRN_W;
                     end
                  end else if (ack_next == ACK_WAIT || ack_next == ACK_FAULT) begin
                     status_in = (ack_next == ACK_WAIT) ? STATUS_WAIT : STATUS_FAULT;
                     phase_in  = (cfg.data_phase_on_wait && is_read) ? PH_WF_RDATA
                                                                     : PH_WF_TRN;
                  end else begin
                     status_in = STATUS_PROTOCOL;
                     phase_in  = PH_ERR;
                  end
               end
            end
            PH_RDATA: begin
               if (!bit_count_ff[5]) begin
                  shift_in  = {item.swdio_sample, shift_ff[31:1]};
                  parity_in = parity_ff ^ item.swdio_sample;
               end else if (parity_ff != item.swdio_sample) begin
                  status_in = STATUS_PARITY;
               end
               bit_count_in = count_inc;
               if (count_inc >= DATA_BITS) begin
                  bit_count_in = 6'd0;
                  phase_in     = PH_TRN_R;
               end
            end
            PH_TRN_R: begin
               bit_count_in = count_inc;
               if (count_inc >= {3'b000, turn_len}) begin
                  bit_count_in = 6'd0;
                  after_ok     = 1'b1;
               end
            end
            PH_TRN_W: begin
               bit_count_in = count_inc;
               if (count_inc >= {3'b000, turn_len}) begin
                  bit_count_in = 6'd0;
                  phase_in     = PH_WDATA;
               end
            end
            PH_WDATA: begin
               drive = 1'b1;
               if (!bit_count_ff[5]) begin
                  level    = shift_ff[0];
                  shift_in = {1'b0, shift_ff[31:1]};
               end else begin
                  level = parity_ff;
               end
               bit_count_in = count_inc;
               if (count_inc >= DATA_BITS) begin
                  bit_count_in = 6'd0;
                  after_ok     = 1'b1;
               end
            end
            PH_IDLECYC: begin
               drive = 1'b1;
               if (idle_count_ff != 8'd0) begin
                  idle_count_in = idle_count_ff - 8'd1;
               end
               if (idle_count_in == 8'd0) begin
                  finish = 1'b1;
               end
            end
            PH_WF_RDATA: begin
               bit_count_in = count_inc;
               if (count_inc >= DATA_BITS) begin
                  bit_count_in = 6'd0;
                  phase_in     = PH_WF_TRN;
               end
            end
            PH_WF_TRN: begin
               bit_count_in = count_inc;
               if (count_inc >= {3'b000, turn_len}) begin
                  bit_count_in = 6'd0;
                  if (cfg.data_phase_on_wait && !is_read) begin
                     phase_in = PH_WF_WDATA;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
            PH_WF_WDATA: begin
               drive        = 1'b1;
               bit_count_in = count_inc;
               if (count_inc >= DATA_BITS) begin
                  bit_count_in = 6'd0;
                  finish       = 1'b1;
               end
            end
            default: begin
               bit_count_in = count_inc;
               if (count_inc >= err_len) begin
                  bit_count_in = 6'd0;
                  finish       = 1'b1;
               end
            end
         endcase

         if (after_ok) begin
            if (cfg.idle_cycle_count == 8'd0) begin
               finish = 1'b1;
            end else begin
               idle_count_in = cfg.idle_cycle_count;
               phase_in      = PH_IDLECYC;
            end
         end

         if (finish) begin
            phase_in     = PH_IDLE;
            bit_count_in = 6'd0;
         end
      end

      result.swdio_out    = level;
      result.swdio_drive  = drive;
      result.clock_active = clock_on;
      result.done_res     = finish;
      result.status       = finish ? status_in : STATUS_OK;
      result.ack_bits     = finish ? ack_in : 3'd0;
      result.read_data    = (finish && is_read && ack_in == ACK_OK) ? shift_in : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 6'd0;
         shift_ff      <= 32'd0;
         parity_ff     <= 1'b0;
         request_ff    <= 4'd0;
         ack_ff        <= 3'd0;
         status_ff     <= STATUS_OK;
         idle_count_ff <= 8'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         parity_ff     <= parity_in;
         request_ff    <= request_in;
         ack_ff        <= ack_in;
         status_ff     <= status_in;
         idle_count_ff <= idle_count_in;
      end
   end

endmodule

// ----- rtl/core/swd_transfer_engine.sv -----
// ----------------------------------------------------------------------------
// SWD transfer engine
// Host-side Serial Wire Debug transfer sequencer with one result per item.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result in the next cycle. A start
// item in idle latches the request and write data; each tick item is one
// SWCLK period and its result carries the SWDIO level, the output enable,
// whether SWCLK pulses, and on the last period of a transfer the status,
// acknowledge and read data. The sequencer advances by one period per item,
// so one item is taken in every cycle; the output register stalls the input
// only while a result waits for a downstream ready. Configuration writes are
// always taken and should be made while no transfer is in progress.
module swd_transfer_engine (
   input logic          clock,
   input logic          reset,
   swdte_chan_if.sink   req_if,
   swdte_chan_if.source rsp_if,
   swdte_chan_if.sink   csr_if
);
   import swdte_pkg::*;

   swdte_cfg_type cfg_ff;
   swdte_rsp_type rsp_data_ff;
   swdte_rsp_type result;
   logic          rsp_valid_ff;
   logic          req_accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   swdte_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .item   (req_if.data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turnaround_cycles  <= 3'd1;
         cfg_ff.data_phase_on_wait <= 1'b0;
         cfg_ff.idle_cycle_count   <= 8'd0;
      end else if (csr_if.valid) begin
         case (csr_if.data.addr)
            CSR_TURNAROUND: cfg_ff.turnaround_cycles  <= csr_if.data.wdata[2:0];
            CSR_DATA_PHASE: cfg_ff.data_phase_on_wait <= csr_if.data.wdata[0];
            CSR_IDLE_COUNT: cfg_ff.idle_cycle_count   <= csr_if.data.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// ----- rtl/core/swdte_checker.sv -----
// ----------------------------------------------------------------------------
// SWD transfer engine checker
// Port-level checks on the item flow and on result fields of the engine.
// ----------------------------------------------------------------------------
module swdte_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input swdte_pkg::swdte_rsp_type rsp_data
);
   import swdte_pkg::*;

   // Every accepted item yields a result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // A stalled result blocks new items.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while a result is stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Completion fields stay zero except on the last period of a transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |->
         rsp_data.status == STATUS_OK && rsp_data.ack_bits == 3'd0 &&
         rsp_data.read_data == 32'd0)
      else $error("completion fields set without done");

   // Without a clock pulse the host always drives SWDIO high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.clock_active |->
         rsp_data.swdio_drive && rsp_data.swdio_out && !rsp_data.done_res)
      else $error("bad result for a period without clock");

endmodule

bind swd_transfer_engine swdte_checker u_swdte_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

// ----- bench/swd_transfer_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD transfer engine testbench
// Plays the target side of SWD transfers against the engine: every start and
// tick item is predicted period by period in the bench and every result item
// is compared field by field. Directed transfers come first, then random ones
// under a series of turnaround, wait/fault data phase and idle settings, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module swd_transfer_engine_test;
   import swdte_pkg::*;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int PHASE_ITEMS    = 100;
   localparam int NUM_SETTINGS   = 7;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_HEADER, SEQ_TURN_ACK, SEQ_ACK, SEQ_READ_DATA, SEQ_TURN_READ,
      SEQ_TURN_WRITE, SEQ_WRITE_DATA, SEQ_IDLE_CYCLES, SEQ_WF_READ, SEQ_WF_TURN,
      SEQ_WF_WRITE, SEQ_ERROR
   } seq_phase_type;

   logic clock;
   logic reset;

   swdte_chan_if #(.payload_type(swdte_req_type)) req_if ();
   swdte_chan_if #(.payload_type(swdte_rsp_type)) rsp_if ();
   swdte_chan_if #(.payload_type(swdte_csr_type)) csr_if ();

   swd_transfer_engine u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predicted engine state and configuration.
   seq_phase_type seq_phase;
   logic [5:0]    bit_cnt;
   logic [31:0]   shifter;
   logic          par_acc;
   logic [3:0]    request_bits;
   logic [2:0]    ack_seen;
   logic [2:0]    status_code;
   logic [7:0]    idle_left;
   logic [2:0]    cfg_turn;
   logic          cfg_wait_data;
   logic [7:0]    cfg_idle;

   // Settings the stimulus is built for.
   logic [2:0] gen_turn;
   logic       gen_wait_data;
   logic [7:0] gen_idle;
   logic       gaps_on;

   logic [2:0] turn_set [NUM_SETTINGS] = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd1, 3'd3, 3'd5};
   logic       dp_set   [NUM_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   logic [7:0] idle_set [NUM_SETTINGS] = '{8'd0, 8'd3, 8'd1, 8'd255, 8'd0, 8'd10, 8'd2};

   swdte_req_type pending_items [$];
   swdte_rsp_type expected_periods [$];

   int fail_count;
   int items_queued;
   int transfers_queued;
   int status_hits [5];
   int gap_left;
   int stall_left;
   int quiet_cycles;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic swdte_rsp_type predict_period(input swdte_req_type it);
      swdte_rsp_type r;
      logic          is_read;
      logic          finish;
      logic          after_ok;
      logic [7:0]    header;
      logic [5:0]    ta;
      r = '0;
      r.clock_active = 1'b1;
      finish = 1'b0;
      after_ok = 1'b0;
      is_read = request_bits[1];
      ta = (cfg_turn == 3'd0) ? 6'd1 : {3'd0, cfg_turn};
      if (it.op == OP_START || seq_phase == SEQ_IDLE) begin
         if (it.op == OP_START && seq_phase == SEQ_IDLE) begin
            request_bits = {it.req_addr, it.req_read, it.req_ap_not_dp};
            shifter = it.write_data;
            par_acc = ^it.write_data;
            ack_seen = '0;
            status_code = STATUS_OK;
            bit_cnt = '0;
            idle_left = '0;
            seq_phase = SEQ_HEADER;
         end
         r.swdio_out = 1'b1;
         r.swdio_drive = 1'b1;
         r.clock_active = 1'b0;
         return r;
      end
      case (seq_phase)
         SEQ_HEADER: begin
            header = 8'h81 | {2'b00, ^request_bits, request_bits, 1'b0};
            r.swdio_drive = 1'b1;
            r.swdio_out = header[bit_cnt[2:0]];
            bit_cnt++;
            if (bit_cnt >= 6'd8) begin
               bit_cnt = '0;
               seq_phase = SEQ_TURN_ACK;
            end
         end
         SEQ_TURN_ACK: begin
            bit_cnt++;
            if (bit_cnt >= ta) begin
               bit_cnt = '0;
               seq_phase = SEQ_ACK;
            end
         end
         SEQ_ACK: begin
            ack_seen = ack_seen | (3'(it.swdio_sample) << bit_cnt[1:0]);
            bit_cnt++;
            if (bit_cnt >= 6'd3) begin
               bit_cnt = '0;
               if (ack_seen == ACK_OK) begin
                  status_code = STATUS_OK;
                  if (is_read) begin
                     shifter = '0;
                     par_acc = 1'b0;
                     seq_phase = SEQ_READ_DATA;
                  end else begin
                     seq_phase = SEQ_TURN_WRITE;
                  end
               end else if (ack_seen == ACK_WAIT || ack_seen == ACK_FAULT) begin
                  status_code = (ack_seen == ACK_WAIT) ? STATUS_WAIT : STATUS_FAULT;
                  seq_phase = (cfg_wait_data && is_read) ? SEQ_WF_READ : SEQ_WF_TURN;
               end else begin
                  status_code = STATUS_PROTOCOL;
                  seq_phase = SEQ_ERROR;
               end
            end
         end
         SEQ_READ_DATA: begin
            if (bit_cnt < 6'd32) begin
               shifter = {it.swdio_sample, shifter[31:1]};
               par_acc = par_acc ^ it.swdio_sample;
            end else if (par_acc != it.swdio_sample) begin
               status_code = STATUS_PARITY;
            end
            bit_cnt++;
            if (bit_cnt >= DATA_BITS) begin
               bit_cnt = '0;
               seq_phase = SEQ_TURN_READ;
            end
         end
         SEQ_TURN_READ: begin
            bit_cnt++;
            if (bit_cnt >= ta) begin
               bit_cnt = '0;
               after_ok = 1'b1;
            end
         end
         SEQ_TURN_WRITE: begin
            bit_cnt++;
            if (bit_cnt >= ta) begin
               bit_cnt = '0;
               seq_phase = SEQ_WRITE_DATA;
            end
         end
         SEQ_WRITE_DATA: begin
            r.swdio_drive = 1'b1;
            if (bit_cnt < 6'd32) begin
               r.swdio_out = shifter[0];
               shifter = shifter >> 1;
            end else begin
               r.swdio_out = par_acc;
            end
            bit_cnt++;
            if (bit_cnt >= DATA_BITS) begin
               bit_cnt = '0;
               after_ok = 1'b1;
            end
         end
         SEQ_IDLE_CYCLES: begin
            r.swdio_drive = 1'b1;
            if (idle_left != 8'd0) idle_left--;
            if (idle_left == 8'd0) finish = 1'b1;
         end
         SEQ_WF_READ: begin
            bit_cnt++;
            if (bit_cnt >= DATA_BITS) begin
               bit_cnt = '0;
               seq_phase = SEQ_WF_TURN;
            end
         end
         SEQ_WF_TURN: begin
            bit_cnt++;
            if (bit_cnt >= ta) begin
               bit_cnt = '0;
               if (cfg_wait_data && !is_read) seq_phase = SEQ_WF_WRITE;
               else finish = 1'b1;
            end
         end
         SEQ_WF_WRITE: begin
            r.swdio_drive = 1'b1;
            bit_cnt++;
            if (bit_cnt >= DATA_BITS) begin
               bit_cnt = '0;
               finish = 1'b1;
            end
         end
         default: begin
            bit_cnt++;
            if (bit_cnt >= ta + DATA_BITS) begin
               bit_cnt = '0;
               finish = 1'b1;
            end
         end
      endcase
      if (after_ok) begin
         if (cfg_idle == 8'd0) begin
            finish = 1'b1;
         end else begin
            idle_left = cfg_idle;
            seq_phase = SEQ_IDLE_CYCLES;
         end
      end
      if (finish) begin
         r.done_res = 1'b1;
         r.status = status_code;
         r.ack_bits = ack_seen;
         r.read_data = (is_read && ack_seen == ACK_OK) ? shifter : '0;
         seq_phase = SEQ_IDLE;
         bit_cnt = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   function automatic swdte_req_type random_item(input logic op, input logic sample);
      swdte_req_type it;
      it.op = op;
      it.req_ap_not_dp = 1'($urandom_range(0, 1));
      it.req_read = 1'($urandom_range(0, 1));
      it.req_addr = 2'($urandom_range(0, 3));
      it.write_data = $urandom;
      it.swdio_sample = sample;
      return it;
   endfunction

   task automatic push_item(input swdte_req_type it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic push_tick(input logic sample, input logic noisy);
      if (noisy && $urandom_range(0, 49) == 0) push_item(random_item(OP_START, 1'($urandom)));
      push_item(random_item(OP_TICK, sample));
   endtask

   // One transfer as seen from the target: the ack, the read word, exactly as
   // many periods as the engine needs to finish, then up to two spare ticks.
   task automatic queue_transfer(input logic ap, input logic rd, input logic [1:0] addr,
                                 input logic [31:0] wdata, input logic [2:0] ack,
                                 input logic bad_parity, input logic [31:0] rdata,
                                 input logic noisy);
      swdte_req_type it;
      int            ta;
      int            rest;
      it = random_item(OP_START, 1'($urandom));
      it.req_ap_not_dp = ap;
      it.req_read = rd;
      it.req_addr = addr;
      it.write_data = wdata;
      push_item(it);
      if (noisy) push_item(random_item(OP_START, 1'($urandom)));
      ta = (gen_turn == 3'd0) ? 1 : int'(gen_turn);
      repeat (8 + ta) push_tick(1'($urandom), noisy);
      for (int i = 0; i < 3; i++) push_tick(ack[i], noisy);
      if (ack == ACK_OK) begin
         if (rd) begin
            for (int i = 0; i < 32; i++) push_tick(rdata[i], noisy);
            push_tick(^rdata ^ bad_parity, noisy);
            rest = ta + int'(gen_idle);
         end else begin
            rest = ta + 33 + int'(gen_idle);
         end
      end else if (ack == ACK_WAIT || ack == ACK_FAULT) begin
         rest = gen_wait_data ? ta + 33 : ta;
      end else begin
         rest = ta + 33;
      end
      repeat (rest) push_tick(1'($urandom), noisy);
      repeat ($urandom_range(0, 2)) push_tick(1'($urandom), 1'b0);
      transfers_queued++;
   endtask

   task automatic random_transfer();
      logic [2:0] ack;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         ack = ACK_OK;
      end else if (r < 72) begin
         ack = ACK_WAIT;
      end else if (r < 84) begin
         ack = ACK_FAULT;
      end else begin
         do ack = 3'($urandom_range(0, 7));
         while (ack == ACK_OK || ack == ACK_WAIT || ack == ACK_FAULT);
      end
      queue_transfer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     2'($urandom_range(0, 3)), $urandom, ack,
                     $urandom_range(0, 9) == 0, $urandom,
                     $urandom_range(0, 9) == 0);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_if.data <= {index, value};
      csr_if.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (pending_items.size() != 0 || expected_periods.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_if.data <= pending_items.pop_front();
            req_if.valid <= 1'b1;
            gap_left <= gaps_on ? pick_gap() : 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 15) begin
         stall_left <= pick_gap();
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: register writes, result checks, then prediction of new items.
   always @(posedge clock) begin
      swdte_rsp_type want;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.data.addr)
               CSR_TURNAROUND: cfg_turn <= csr_if.data.wdata[2:0];
               CSR_DATA_PHASE: cfg_wait_data <= csr_if.data.wdata[0];
               CSR_IDLE_COUNT: cfg_idle <= csr_if.data.wdata;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_periods.size() == 0) begin
               $error("result item arrived with no expected item waiting");
               fail_count++;
            end else begin
               want = expected_periods.pop_front();
               check_field("swdio_out", 32'(want.swdio_out), 32'(rsp_if.data.swdio_out));
               check_field("swdio_drive", 32'(want.swdio_drive),
                           32'(rsp_if.data.swdio_drive));
               check_field("clock_active", 32'(want.clock_active),
                           32'(rsp_if.data.clock_active));
               check_field("done_res", 32'(want.done_res), 32'(rsp_if.data.done_res));
               check_field("status", 32'(want.status), 32'(rsp_if.data.status));
               check_field("ack_bits", 32'(want.ack_bits), 32'(rsp_if.data.ack_bits));
               check_field("read_data", want.read_data, rsp_if.data.read_data);
               if (want.done_res && want.status <= STATUS_PROTOCOL) status_hits[want.status]++;
            end
         end
         if (req_if.valid && req_if.ready) expected_periods.push_back(predict_period(req_if.data));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_start;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      seq_phase = SEQ_IDLE;
      bit_cnt = '0;
      shifter = '0;
      par_acc = 1'b0;
      request_bits = '0;
      ack_seen = '0;
      status_code = STATUS_OK;
      idle_left = '0;
      cfg_turn = 3'd1;
      cfg_wait_data = 1'b0;
      cfg_idle = 8'd0;
      gen_turn = 3'd1;
      gen_wait_data = 1'b0;
      gen_idle = 8'd0;
      gaps_on = 1'b1;
      fail_count = 0;
      items_queued = 0;
      transfers_queued = 0;
      quiet_cycles = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed transfers under the reset settings.
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      queue_transfer(1'b1, 1'b0, 2'd3, 32'hFFFF_FFFF, ACK_OK, 1'b0, '0, 1'b1);
      queue_transfer(1'b0, 1'b1, 2'd0, '0, ACK_OK, 1'b0, '0, 1'b0);
      queue_transfer(1'b1, 1'b1, 2'd2, '0, ACK_OK, 1'b1, 32'hFFFF_FFFF, 1'b0);
      queue_transfer(1'b0, 1'b1, 2'd1, '0, ACK_WAIT, 1'b0, '0, 1'b0);
      queue_transfer(1'b1, 1'b0, 2'd1, 32'hA5A5_0F0F, ACK_FAULT, 1'b0, '0, 1'b0);
      queue_transfer(1'b0, 1'b1, 2'd3, '0, ACK_OK | ACK_WAIT | ACK_FAULT, 1'b0, '0, 1'b0);
      queue_transfer(1'b1, 1'b0, 2'd2, '0, 3'b000, 1'b0, '0, 1'b0);
      wait_drain();

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         gaps_on = (p != 2);
         gen_turn = turn_set[p];
         gen_wait_data = dp_set[p];
         gen_idle = idle_set[p];
         write_reg(CSR_TURNAROUND, {5'd0, gen_turn});
         write_reg(CSR_DATA_PHASE, {7'd0, gen_wait_data});
         write_reg(CSR_IDLE_COUNT, gen_idle);
         repeat (2) @(posedge clock);
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) random_transfer();
         wait_drain();
      end

      repeat (8) @(posedge clock);
      if (expected_periods.size() != 0) begin
         $error("%0d expected result items never arrived", expected_periods.size());
         fail_count++;
      end
      $display("Ran %0d transfers in %0d items over %0d register settings.",
               transfers_queued, items_queued, NUM_SETTINGS + 1);
      $display("Done status seen: ok %0d, wait %0d, fault %0d, parity %0d, protocol %0d.",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4]);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
